FILE: sv/spcd_pkg.sv
// Shared constants and control types of the spectral peak cluster detector.
// Used by the channel interfaces, controller, datapath and top level.
`default_nettype none

package spcd_pkg;

  // Sizing
  localparam int MAX_BINS    = 1024;
  localparam int MAX_PEAKS   = 64;
  localparam int SAMPLE_BITS = 24;

  localparam int IN_W       = 24;                       // bin component field
  localparam int CFG_W      = 24;                       // configuration data
  localparam int CFG_IDX_W  = 2;                        // register index field
  localparam int FREQ_W     = 34;                       // peak frequency field
  localparam int SQ_W       = 2 * SAMPLE_BITS;
  localparam int MAG_W      = 2 * SAMPLE_BITS + 1;
  localparam int BIN_AW     = $clog2(MAX_BINS);
  localparam int CNT_W      = $clog2(MAX_BINS + 1);
  localparam int SUM_W      = 21;
  localparam int PROD_W     = SUM_W + CFG_W;
  localparam int GPROD_W    = BIN_AW + CFG_W;
  localparam int PEAK_CNT_W = $clog2(MAX_PEAKS + 1);
  localparam int DIV_CNT_W  = $clog2(PROD_W + 1);

  // Register map
  localparam logic [CFG_IDX_W-1:0] REG_BIN_SPACING = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MERGE_GAP   = 2'd1;

  localparam logic [CFG_W-1:0] BIN_SPACING_RST = 24'd6000;
  localparam logic [CFG_W-1:0] MERGE_GAP_RST   = 24'd1280;

  // Controller to datapath
  typedef struct packed {
    logic in_accept;
    logic scan_init;
    logic rd_issue;
    logic eval;
    logic skip;
    logic add_bin;
    logic mul;
    logic div_step;
    logic drop;
    logic pend_load;
    logic push_pend;
    logic push_last;
    logic push_nopeak;
    logic frame_clear;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic pipe_empty;
    logic scan_end;
    logic sel;
    logic gap_hit;
    logic count_nz;
    logic div_last;
    logic peaks_full;
    logic pend_valid;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

FILE: sv/spcd_if.sv
// Valid/ready channel interfaces: spectrum bins in, peak results out, config writes.
// Depends on spcd_pkg for field widths.
`default_nettype none

interface spcd_in_if;
  import spcd_pkg::*;
  logic                   valid;
  logic                   ready;
  logic signed [IN_W-1:0] bin_real;
  logic signed [IN_W-1:0] bin_imag;
  logic                   last_bin;

  modport source (output valid, bin_real, bin_imag, last_bin, input ready);
  modport sink   (input valid, bin_real, bin_imag, last_bin, output ready);
endinterface

interface spcd_out_if;
  import spcd_pkg::*;
  logic              valid;
  logic              ready;
  logic [FREQ_W-1:0] peak_freq_q8;
  logic              no_peak;
  logic              truncated;
  logic              last_peak;

  modport source (output valid, peak_freq_q8, no_peak, truncated, last_peak, input ready);
  modport sink   (input valid, peak_freq_q8, no_peak, truncated, last_peak, output ready);
endinterface

interface spcd_cfg_if;
  import spcd_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] reg_index;
  logic [CFG_W-1:0]     wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink   (input valid, reg_index, wdata, output ready);
endinterface

`default_nettype wire

FILE: sv/spcd_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
`default_nettype none

module spcd_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [W-1:0]             wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [W-1:0]             rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: sv/spcd_ctrl.sv
// Sequencer of the peak cluster detector: bin intake, store scan, cluster
// division and result hand-off. Depends on spcd_pkg; drives spcd_dp by cmd_t.
`default_nettype none

module spcd_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  input  wire logic            in_last,
  output logic                 in_ready,
  input  wire spcd_pkg::sts_t  sts,
  output spcd_pkg::cmd_t       cmd
);
  import spcd_pkg::*;

  typedef enum logic [8:0] {
    S_LOAD  = 9'b000000001,
    S_DRAIN = 9'b000000010,
    S_READ  = 9'b000000100,
    S_WAIT  = 9'b000001000,
    S_TEST  = 9'b000010000,
    S_MUL   = 9'b000100000,
    S_DIV   = 9'b001000000,
    S_EMIT  = 9'b010000000,
    S_LAST  = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;
  logic   fin_r, fin_nxt;
  logic   emit_done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      fin_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fin_r   <= fin_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    fin_nxt   = fin_r;
    cmd       = '0;
    in_ready  = 1'b0;
    emit_done = 1'b0;
    case (state_r)
      S_LOAD: begin
        in_ready      = 1'b1;
        cmd.in_accept = in_valid;
        if (in_valid && in_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        // wait for the squaring pipeline to land its last write
        if (sts.pipe_empty) begin
          cmd.scan_init = 1'b1;
          state_nxt     = S_READ;
        end
      end
      S_READ: begin
        if (sts.scan_end) begin
          fin_nxt   = 1'b1;
          state_nxt = sts.count_nz ? S_MUL : S_LAST;
        end else begin
          cmd.rd_issue = 1'b1;
          state_nxt    = S_WAIT;
        end
      end
      S_WAIT: begin
        cmd.eval  = 1'b1;
        state_nxt = S_TEST;
      end
      S_TEST: begin
        if (!sts.sel) begin
          cmd.skip  = 1'b1;
          state_nxt = S_READ;
        end else if (sts.count_nz && sts.gap_hit) begin
          // close the open cluster; this bin starts the next one after emit
          state_nxt = S_MUL;
        end else begin
          cmd.add_bin = 1'b1;
          state_nxt   = S_READ;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (sts.peaks_full) begin
          cmd.drop  = 1'b1;
          emit_done = 1'b1;
        end else if (!sts.pend_valid) begin
          cmd.pend_load = 1'b1;
          emit_done     = 1'b1;
        end else if (sts.out_free) begin
          // hand the held result on, hold the new one until its successor shows
          cmd.push_pend = 1'b1;
          cmd.pend_load = 1'b1;
          emit_done     = 1'b1;
        end
        if (emit_done) begin
          if (fin_r) begin
            state_nxt = S_LAST;
          end else begin
            cmd.add_bin = 1'b1;
            state_nxt   = S_READ;
          end
        end
      end
      S_LAST: begin
        if (sts.out_free) begin
          if (sts.pend_valid) begin
            cmd.push_pend = 1'b1;
            cmd.push_last = 1'b1;
          end else begin
            cmd.push_nopeak = 1'b1;
          end
          cmd.frame_clear = 1'b1;
          fin_nxt         = 1'b0;
          state_nxt       = S_LOAD;
        end
      end
      default: begin
        state_nxt = S_LOAD;
        fin_nxt   = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: sv/spcd_dp.sv
// Datapath of the peak cluster detector: magnitude pipeline, bin store,
// threshold and gap tests, mean divider, result registers and config registers.
// Depends on spcd_pkg and spcd_ram.
`default_nettype none

module spcd_dp (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic signed [spcd_pkg::IN_W-1:0] in_bin_real,
  input  wire logic signed [spcd_pkg::IN_W-1:0] in_bin_imag,
  input  wire logic                             cfg_valid,
  input  wire logic [spcd_pkg::CFG_IDX_W-1:0]   cfg_reg_index,
  input  wire logic [spcd_pkg::CFG_W-1:0]       cfg_wdata,
  input  wire logic                             out_ready,
  output logic                                  out_valid,
  output logic [spcd_pkg::FREQ_W-1:0]           out_peak_freq_q8,
  output logic                                  out_no_peak,
  output logic                                  out_truncated,
  output logic                                  out_last_peak,
  input  wire spcd_pkg::cmd_t                   cmd,
  output spcd_pkg::sts_t                        sts
);
  import spcd_pkg::*;

  function automatic logic [SAMPLE_BITS-1:0] abs_comp(input logic [IN_W-1:0] raw);
    logic [SAMPLE_BITS-1:0] v;
    v = raw[SAMPLE_BITS-1:0];
    abs_comp = v[SAMPLE_BITS-1] ? (~v + 1'b1) : v;
  endfunction

  // Configuration
  logic [CFG_W-1:0] spacing_r, gap_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spacing_r <= BIN_SPACING_RST;
      gap_r     <= MERGE_GAP_RST;
    end else if (cfg_valid) begin
      case (cfg_reg_index)
        REG_BIN_SPACING: spacing_r <= cfg_wdata;
        REG_MERGE_GAP:   gap_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Magnitude pipeline: abs, square, sum and store
  logic                   store_ok;
  logic [CNT_W-1:0]       bins_r;
  logic                   a_wr_r, b_wr_r;
  logic [SAMPLE_BITS-1:0] a_re_r, a_im_r;
  logic [BIN_AW-1:0]      a_addr_r, b_addr_r;
  logic [SQ_W-1:0]        sqr_r, sqi_r;
  logic [MAG_W-1:0]       mag, max_r;

  assign store_ok = bins_r < CNT_W'(MAX_BINS);
  assign mag      = MAG_W'(sqr_r) + MAG_W'(sqi_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_wr_r <= 1'b0;
      b_wr_r <= 1'b0;
      bins_r <= '0;
      max_r  <= '0;
    end else begin
      a_wr_r <= cmd.in_accept && store_ok;
      b_wr_r <= a_wr_r;
      if (cmd.in_accept && store_ok) begin
        bins_r <= bins_r + 1'b1;
      end else if (cmd.frame_clear) begin
        bins_r <= '0;
      end
      if (b_wr_r && (mag > max_r)) begin
        max_r <= mag;
      end else if (cmd.frame_clear) begin
        max_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    a_re_r   <= abs_comp(in_bin_real);
    a_im_r   <= abs_comp(in_bin_imag);
    a_addr_r <= bins_r[BIN_AW-1:0];
    sqr_r    <= a_re_r * a_re_r;
    sqi_r    <= a_im_r * a_im_r;
    b_addr_r <= a_addr_r;
  end

  // Bin store
  logic [CNT_W-1:0] k_r;
  logic [MAG_W-1:0] rd_mag;

  spcd_ram #(
    .W     (MAG_W),
    .DEPTH (MAX_BINS)
  ) u_store (
    .clk   (clk),
    .we    (b_wr_r),
    .waddr (b_addr_r),
    .wdata (mag),
    .re    (cmd.rd_issue),
    .raddr (k_r[BIN_AW-1:0]),
    .rdata (rd_mag)
  );

  // Scan: threshold and merge-gap tests
  logic [MAG_W+4:0]   mag25;
  logic [BIN_AW-1:0]  diff, prev_r;
  logic [GPROD_W-1:0] gprod, gprod_r;
  logic               sel_r;
  logic [SUM_W-1:0]   sum_r;
  logic [CNT_W-1:0]   cnt_r;

  // 25 * mag against max: magnitude above a fifth of the peak magnitude
  assign mag25 = {rd_mag, 4'b0} + {1'b0, rd_mag, 3'b0} + {5'b0, rd_mag};
  assign diff  = k_r[BIN_AW-1:0] - prev_r;
  assign gprod = diff * spacing_r;

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      sel_r   <= mag25 > {5'b0, max_r};
      gprod_r <= gprod;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r    <= '0;
      sum_r  <= '0;
      cnt_r  <= '0;
      prev_r <= '0;
    end else begin
      if (cmd.scan_init) begin
        k_r <= '0;
      end else if (cmd.skip || cmd.add_bin) begin
        k_r <= k_r + 1'b1;
      end
      if (cmd.frame_clear) begin
        sum_r  <= '0;
        cnt_r  <= '0;
        prev_r <= '0;
      end else if (cmd.mul) begin
        sum_r <= '0;
        cnt_r <= '0;
      end else if (cmd.add_bin) begin
        sum_r  <= sum_r + SUM_W'(k_r[BIN_AW-1:0]);
        cnt_r  <= cnt_r + 1'b1;
        prev_r <= k_r[BIN_AW-1:0];
      end
    end
  end

  // Mean: product of index sum and spacing, then restoring division by count
  logic [PROD_W-1:0]    quo_r;
  logic [CNT_W-1:0]     rem_r, dvs_r;
  logic [DIV_CNT_W-1:0] dcnt_r;
  logic [CNT_W:0]       trial;
  logic                 q_bit;

  assign trial = {rem_r, quo_r[PROD_W-1]};
  assign q_bit = trial >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      quo_r <= sum_r * spacing_r;
      rem_r <= '0;
      dvs_r <= cnt_r;
    end else if (cmd.div_step) begin
      quo_r <= {quo_r[PROD_W-2:0], q_bit};
      rem_r <= q_bit ? CNT_W'(trial - {1'b0, dvs_r}) : trial[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dcnt_r <= '0;
    end else if (cmd.mul) begin
      dcnt_r <= DIV_CNT_W'(PROD_W);
    end else if (cmd.div_step) begin
      dcnt_r <= dcnt_r - 1'b1;
    end
  end

  // Held result, emitted count and the output register
  logic [PEAK_CNT_W-1:0] peaks_r;
  logic                  dropped_r;
  logic                  pend_valid_r;
  logic [FREQ_W-1:0]     pend_freq_r;
  logic                  out_valid_r;
  logic                  out_free;
  logic                  push;

  assign out_free = !out_valid_r || out_ready;
  assign push     = cmd.push_pend || cmd.push_nopeak;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      peaks_r      <= '0;
      dropped_r    <= 1'b0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cmd.frame_clear) begin
        peaks_r      <= '0;
        dropped_r    <= 1'b0;
        pend_valid_r <= 1'b0;
      end else begin
        if (cmd.pend_load) begin
          peaks_r      <= peaks_r + 1'b1;
          pend_valid_r <= 1'b1;
        end
        if (cmd.drop) begin
          dropped_r <= 1'b1;
        end
      end
      if (push) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pend_load) begin
      pend_freq_r <= quo_r[FREQ_W-1:0];
    end
    if (cmd.push_pend) begin
      out_peak_freq_q8 <= pend_freq_r;
      out_no_peak      <= 1'b0;
      out_truncated    <= cmd.push_last && dropped_r;
      out_last_peak    <= cmd.push_last;
    end else if (cmd.push_nopeak) begin
      out_peak_freq_q8 <= '0;
      out_no_peak      <= 1'b1;
      out_truncated    <= 1'b0;
      out_last_peak    <= 1'b1;
    end
  end

  assign out_valid = out_valid_r;

  always_comb begin
    sts            = '0;
    sts.pipe_empty = !a_wr_r && !b_wr_r;
    sts.scan_end   = k_r == bins_r;
    sts.sel        = sel_r;
    sts.gap_hit    = gprod_r >= GPROD_W'(gap_r);
    sts.count_nz   = cnt_r != '0;
    sts.div_last   = dcnt_r == DIV_CNT_W'(1);
    sts.peaks_full = peaks_r == PEAK_CNT_W'(MAX_PEAKS);
    sts.pend_valid = pend_valid_r;
    sts.out_free   = out_free;
  end

  // Checks
  a_scan_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_issue |-> (!a_wr_r && !b_wr_r))
    else $error("store read while bin writes still in flight");

  a_push_into_free: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> out_free)
    else $error("result pushed over an unaccepted one");

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |-> (dvs_r != '0))
    else $error("mean division by a zero member count");

  a_mean_fits: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pend_load |-> (quo_r[PROD_W-1:FREQ_W] == '0))
    else $error("cluster mean exceeds the frequency field");

  a_peaks_bound: assert property (@(posedge clk) disable iff (!rst_n)
    peaks_r <= PEAK_CNT_W'(MAX_PEAKS))
    else $error("emitted cluster count beyond limit");

endmodule

`default_nettype wire

FILE: sv/spectral_peak_cluster_detector.sv
// Spectral peak cluster detector: bins one per cycle in while loading, one result
// per cluster out (at most 64), with a relative threshold and frequency-gap
// merging. Depends on spcd_pkg, spcd_if, spcd_ctrl and spcd_dp.
//
// Bins are accepted one per clock while loading; each squared magnitude goes
// through an abs/square/sum pipeline into a 1024-entry store, bins past the
// 1024th are not stored. The bin flagged last_bin closes the spectrum: intake
// stops, the pipeline drains and the scan starts, and the controller scans the
// store bin by bin (store read, threshold and gap test, decision). Each
// cluster's mean then takes the product of index sum and spacing, the
// bit-per-cycle divider by the member count, and a step to hand the result
// on.
// Results leave through a holding register and an output register, so a slow
// consumer only stalls the scan when a new result is ready while the output
// register still holds an unaccepted one; intake reopens once the final result
// (last_peak) is registered.
// The store needs no clearing pass after reset. Configuration registers are
// always ready and are meant to be written between spectra.
`default_nettype none

module spectral_peak_cluster_detector (
  input  wire logic  clk,
  input  wire logic  rst_n,
  spcd_in_if.sink    in_ch,
  spcd_out_if.source out_ch,
  spcd_cfg_if.sink   cfg_ch
);
  import spcd_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ch.ready = 1'b1;

  spcd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_last  (in_ch.last_bin),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  spcd_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_bin_real      (in_ch.bin_real),
    .in_bin_imag      (in_ch.bin_imag),
    .cfg_valid        (cfg_ch.valid),
    .cfg_reg_index    (cfg_ch.reg_index),
    .cfg_wdata        (cfg_ch.wdata),
    .out_ready        (out_ch.ready),
    .out_valid        (out_ch.valid),
    .out_peak_freq_q8 (out_ch.peak_freq_q8),
    .out_no_peak      (out_ch.no_peak),
    .out_truncated    (out_ch.truncated),
    .out_last_peak    (out_ch.last_peak),
    .cmd              (cmd),
    .sts              (sts)
  );

endmodule

`default_nettype wire
